// File: hdl/lkc_pkg.sv
`timescale 1ns / 1ps
// Package: shared constants, control struct and key folding for the LRU key cache.
package lkc_pkg;

  localparam int CACHE_DEPTH = 32;
  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 64;
  localparam int CAP_W       = 6;
  localparam int COST_W      = 3;
  localparam int SUM_W       = 32;
  localparam int IDX_W       = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

  localparam logic [COST_W-1:0] COST_HIT  = 3'd1;
  localparam logic [COST_W-1:0] COST_MISS = 3'd5;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic advance;
    logic flush;
  } cell_ctrl_t;

  // fold A..Z to lower case
  function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] res;
    logic [7:0]       ch;
    res = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      ch = raw[8*b +: 8];
      if (ch >= 8'h41 && ch <= 8'h5A) begin
        ch = ch + 8'h20;
      end
      res[8*b +: 8] = ch;
    end
    return res;
  endfunction

endpackage

// File: hdl/lkc_cell.sv
`timescale 1ns / 1ps
// One cache slot: holds a key and its valid bit, compares and shifts in from its neighbour.
module lkc_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lkc_pkg::cell_ctrl_t      ctrl_i,
  input  logic [lkc_pkg::KEY_W-1:0] key_i,
  input  logic [lkc_pkg::KEY_W-1:0] prev_key_i,
  input  logic                     prev_valid_i,
  input  logic                     seen_i,
  input  logic                     drop_i,
  output logic [lkc_pkg::KEY_W-1:0] key_o,
  output logic                     valid_o,
  output logic                     seen_o,
  output logic                     nxt_valid_o
);
  import lkc_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic             valid_q;
  logic             valid_d;
  logic             shift;
  logic             match;

  // shift in from the newer neighbour unless the hit lies nearer the head
  assign shift       = ~seen_i;
  assign match       = valid_q && (key_q == key_i);
  assign seen_o      = seen_i | match;
  assign nxt_valid_o = shift ? prev_valid_i : valid_q;
  assign key_o       = key_q;
  assign valid_o     = valid_q;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.advance) begin
      valid_d = ctrl_i.flush ? 1'b0 : (nxt_valid_o & ~drop_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance && shift) begin
      key_q <= prev_key_i;
    end
  end

endmodule

// File: hdl/lru_key_cache_cost_counter.sv
`timescale 1ns / 1ps
// Top level: LRU key cache built as a row of shifting cells, with cost accounting.
//
// Takes one key word per cycle and returns one result word per key, registered after the
// fold stage in the output register. The first stage folds the key to lower case
// and registers it; the second stage broadcasts it to a row of CACHE_DEPTH cells that
// each compare it against their stored key in parallel. Cell 0 holds the most recent
// entry. On a hit the cells from the head down to the matching one shift by one and the
// key lands in cell 0 (cost 1); on a miss the whole row shifts (cost 5) and the oldest
// entry falls off the tail when storage is full. If the number of valid cells then
// exceeds cache_capacity, the oldest valid cell is dropped, one per key. The running
// total saturates at all ones. After a word with tlast set, the cache contents and the
// total are cleared for the next list; cache_capacity is kept. A new word can be taken
// every cycle: the compare, the ripple of the hit mark along the row and the shift of
// the cells all settle within the second stage. While a result word waits
// on the output, the fold stage holds one more word and then the input stalls.
// cache_capacity must only be written while no word is in flight.
module lru_key_cache_cost_counter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_wr_en_i,
  input  logic [lkc_pkg::CAP_W-1:0]   cfg_wr_data_i,   // cache_capacity
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,    // [63:0] key_text
  input  logic                        s_axis_tlast,    // end_of_list
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [39:0]                 m_axis_tdata,    // [0] hit, [3:1] access_cost,
                                                       // [35:4] total_cost, [39:36] zero
  output logic                        m_axis_tlast     // last_result
);
  import lkc_pkg::*;

  // configuration register
  logic [CAP_W-1:0] cap_q;

  // fold stage
  logic             a_valid_q;
  logic [KEY_W-1:0] a_key_q;
  logic             a_last_q;
  logic             a_fire;
  logic             in_fire;

  // output register
  logic             out_valid_q;
  logic             out_hit_q;
  logic [COST_W-1:0] out_cost_q;
  logic [SUM_W-1:0] out_total_q;
  logic             out_last_q;

  // running total
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] sum_d;
  logic [SUM_W:0]   sum_wide;

  // cell row
  cell_ctrl_t       ctrl;
  logic [KEY_W-1:0] cell_key  [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] cell_vld;
  logic [CACHE_DEPTH-1:0] cell_nvld;
  logic [CACHE_DEPTH-1:0] cell_drop;
  logic [CACHE_DEPTH:0]   seen;
  logic             hit_now;
  logic             drop_now;
  logic [COST_W-1:0] cost_now;

  // advance the row when the output register is free or being emptied
  assign a_fire        = a_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !a_valid_q || a_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else if (cfg_wr_en_i) begin
      cap_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_fire) begin
      a_valid_q <= 1'b1;
    end else if (a_fire) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_key_q  <= fold_key(s_axis_tdata);
      a_last_q <= s_axis_tlast;
    end
  end

  assign ctrl.advance = a_fire;
  assign ctrl.flush   = a_last_q;
  assign seen[0]      = 1'b0;

  for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      lkc_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .key_i       (a_key_q),
        .prev_key_i  (a_key_q),
        .prev_valid_i(1'b1),
        .seen_i      (seen[i]),
        .drop_i      (cell_drop[i]),
        .key_o       (cell_key[i]),
        .valid_o     (cell_vld[i]),
        .seen_o      (seen[i+1]),
        .nxt_valid_o (cell_nvld[i])
      );
    end else begin : g_body
      lkc_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .key_i       (a_key_q),
        .prev_key_i  (cell_key[i-1]),
        .prev_valid_i(cell_vld[i-1]),
        .seen_i      (seen[i]),
        .drop_i      (cell_drop[i]),
        .key_o       (cell_key[i]),
        .valid_o     (cell_vld[i]),
        .seen_o      (seen[i+1]),
        .nxt_valid_o (cell_nvld[i])
      );
    end

    // drop the oldest valid cell (top of the thermometer) when over capacity
    if (i == CACHE_DEPTH - 1) begin : g_tail
      assign cell_drop[i] = drop_now & cell_nvld[i];
    end else begin : g_mid
      assign cell_drop[i] = drop_now & cell_nvld[i] & ~cell_nvld[i+1];
    end
  end

  assign hit_now = seen[CACHE_DEPTH];

  // valid cells form a thermometer, so over capacity means the cell at that index is set
  always_comb begin
    drop_now = 1'b0;
    if (32'(cap_q) < CACHE_DEPTH) begin
      drop_now = cell_nvld[IDX_W'(cap_q)];
    end
  end

  assign cost_now = hit_now ? COST_HIT : COST_MISS;
  assign sum_wide = {1'b0, sum_q} + {{(SUM_W+1-COST_W){1'b0}}, cost_now};
  assign sum_d    = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (a_fire) begin
      sum_q <= a_last_q ? '0 : sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (a_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      out_hit_q   <= hit_now;
      out_cost_q  <= cost_now;
      out_total_q <= sum_d;
      out_last_q  <= a_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_total_q, out_cost_q, out_hit_q};
  assign m_axis_tlast  = out_last_q;

  // cost always agrees with the hit flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_hit_q ? (out_cost_q == COST_HIT) : (out_cost_q == COST_MISS)))
    else $error("access cost disagrees with hit flag");

  // valid cells stay packed from the head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, cell_vld} + {{CACHE_DEPTH{1'b0}}, 1'b1}))
    else $error("cell valid bits not contiguous");

  // the end of a list empties the cache
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_fire && a_last_q) |=> (cell_vld == '0))
    else $error("cache not cleared after last word");

  // an empty cache with zero capacity stores nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_fire && cap_q == '0 && cell_vld == '0) |=> (cell_vld == '0))
    else $error("cell left valid with zero capacity");

endmodule
